/* src/dmpi_pkg.sv */
`default_nettype none

package dmpi_pkg;

  // Shared multiplier operand and accumulator widths
  localparam int MUL_W = 27;
  localparam int ACC_W = 2 * MUL_W;

  // Restoring divider: |diff * 100| <= 25500 over a 16-bit millisecond count
  localparam int DIV_NUM_W = 15;
  localparam int DIV_DEN_W = 16;

  // Quotient width of |out| * 100 / 255
  localparam int DUTY_Q_W = 14;

  localparam logic signed [MUL_W-1:0] K_HUNDRED    = 27'sd100;
  localparam logic signed [MUL_W-1:0] K_FILT_KEEP  = 27'sd55968;
  localparam logic signed [MUL_W-1:0] K_FILT_NEW   = 27'sd4771;
  localparam logic signed [MUL_W-1:0] K_MS_PER_S   = 27'sd1000;

  // ceil(2^35 / 1000): exact floor division for magnitudes below 2^25
  localparam logic signed [MUL_W-1:0] K_RECIP_MS   = 27'sd34359739;
  localparam int                      RECIP_MS_SH  = 35;
  // ceil(2^30 / 255): exact floor division for magnitudes below 2^22
  localparam logic signed [MUL_W-1:0] K_RECIP_DUTY = 27'sd4210753;
  localparam int                      RECIP_DUTY_SH = 30;

  // Integral sum limits, beyond which the quotient by 1000 saturates
  localparam logic signed [ACC_W-1:0] INT_SUM_HI = 54'sd32768000;
  localparam logic signed [ACC_W-1:0] INT_SUM_LO = -54'sd32769000;

  localparam logic [6:0]  DUTY_MAX       = 7'd100;
  localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd0;

  localparam logic [0:0] REG_PROP_GAIN  = 1'b0;
  localparam logic [0:0] REG_INTEG_GAIN = 1'b1;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_STOP   = 1'b1;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_LOAD,
    MAC_ADD
  } mac_mode_t;

  typedef struct packed {
    mac_mode_t               mode;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mac_req_t;

endpackage

`default_nettype wire

/* src/dmpi_if.sv */
`default_nettype none

interface dmpi_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic signed [7:0] count_m1;
  logic signed [7:0] count_m2;
  logic [15:0]       elapsed_ms;
  logic [7:0]        target_speed;

  modport source (output valid, action, count_m1, count_m2, elapsed_ms, target_speed,
                  input ready);
  modport sink (input valid, action, count_m1, count_m2, elapsed_ms, target_speed,
                output ready);
endinterface

interface dmpi_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] duty_m1;
  logic       reverse_m1;
  logic [6:0] duty_m2;
  logic       reverse_m2;

  modport source (output valid, duty_m1, reverse_m1, duty_m2, reverse_m2, input ready);
  modport sink (input valid, duty_m1, reverse_m1, duty_m2, reverse_m2, output ready);
endinterface

`default_nettype wire

/* src/dual_motor_pi_speed_controller.sv */
// Channel   Dir  Payload                                             Handshake
// update    in   action, count_m1, count_m2, elapsed_ms, target_speed  valid/ready
// result    out  duty_m1, reverse_m1, duty_m2, reverse_m2             valid/ready
// cfg       in   cfg_index, cfg_data (prop_gain, integ_gain)          cfg_wr_en
//
// An update request is worked through one motor at a time, motor 1 then motor 2, using
// the shared 27x27 multiply-accumulate unit and the 15-step restoring divider.
// A stop request skips the arithmetic and registers an all-zero result once the slot frees.
// rst is synchronous; it clears the controller state and loads the default gains.
// update.ready is high only while idle; a result waiting on result.ready does not
// block the next request, but that request's result holds until the slot frees.
`default_nettype none

module dual_motor_pi_speed_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  dmpi_in_if.sink          update,
  dmpi_out_if.source       result
);

  localparam int MW = dmpi_pkg::MUL_W;
  localparam int AW = dmpi_pkg::ACC_W;
  localparam int NW = dmpi_pkg::DIV_NUM_W;
  localparam int QW = dmpi_pkg::DUTY_Q_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RAW_MUL, S_RAW_WAIT, S_RAW_DIV, S_DIV_WAIT,
    S_FLT_A, S_FLT_B, S_FLT_C, S_FLT_WAIT, S_FLT_SET,
    S_INT_A, S_INT_B, S_INT_WAIT, S_INT_CLAMP, S_INT_MUL, S_INT_WAIT2, S_INT_SET,
    S_OUT_A, S_OUT_B, S_OUT_WAIT, S_OUT_SET,
    S_DTY_A, S_DTY_WAIT, S_DTY_B, S_DTY_WAIT2, S_DTY_SET,
    S_DONE
  } state_t;

  state_t state;
  logic   m;

  logic [15:0] prop_gain;
  logic [15:0] integ_gain;

  logic signed [7:0]  cnt      [2];
  logic signed [7:0]  last_cnt [2];
  logic signed [15:0] filt     [2];
  logic signed [15:0] prev_raw [2];
  logic signed [15:0] integ    [2];
  logic [6:0]         duty_t   [2];
  logic               rev_t    [2];

  logic [15:0] ms_eff;
  logic [7:0]  target;

  logic signed [15:0] raw_r;
  logic signed [15:0] filt_n;
  logic signed [15:0] integ_n;
  logic signed [15:0] out_n;
  logic               raw_neg;
  logic               int_neg;
  logic               int_sat;
  logic [24:0]        int_mag;

  logic       res_valid;
  logic [6:0] res_duty1;
  logic       res_rev1;
  logic [6:0] res_duty2;
  logic       res_rev2;

  dmpi_pkg::mac_req_t   mac_req;
  logic signed [AW-1:0] acc;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic          div_done;
  logic [NW-1:0] div_q;

  logic signed [8:0]    diff;
  logic signed [17:0]   err;
  logic [15:0]          out_mag;
  logic signed [AW-1:0] rnd16;
  logic signed [AW-1:0] rnd8;
  logic signed [AW-1:0] acc_q16;
  logic signed [AW-1:0] acc_q8;
  logic signed [AW-1:0] acc_abs;
  logic [15:0]          int_q;
  logic [15:0]          q16;
  logic [QW-1:0]        dm;

  function automatic logic signed [15:0] sat16(input logic signed [AW-1:0] v);
    logic signed [15:0] r;
    if (v > AW'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(AW'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    diff    = {cnt[m][7], cnt[m]} - {last_cnt[m][7], last_cnt[m]};
    err     = $signed({10'd0, target}) - $signed({{2{filt_n[15]}}, filt_n});
    out_mag = out_n[15] ? (16'd0 - out_n) : out_n;
    // Round toward zero before the arithmetic shift
    rnd16   = acc[AW-1] ? AW'(65535) : AW'(0);
    rnd8    = acc[AW-1] ? AW'(255) : AW'(0);
    acc_q16 = (acc + rnd16) >>> 16;
    acc_q8  = (acc + rnd8) >>> 8;
    acc_abs = acc[AW-1] ? -acc : acc;
    int_q   = acc[dmpi_pkg::RECIP_MS_SH +: 16];
    q16     = 16'(div_q);
    dm      = acc[dmpi_pkg::RECIP_DUTY_SH +: QW];
    div_num = acc[AW-1] ? NW'(16'd0 - acc[15:0]) : acc[NW-1:0];
  end

  assign div_start = (state == S_RAW_DIV);

  // Operand select for the shared multiplier
  always_comb begin
    mac_req = '{mode: dmpi_pkg::MAC_IDLE, a: '0, b: '0};
    unique case (state)
      S_RAW_MUL: mac_req = '{dmpi_pkg::MAC_LOAD, MW'(diff), dmpi_pkg::K_HUNDRED};
      S_FLT_A:   mac_req = '{dmpi_pkg::MAC_LOAD, dmpi_pkg::K_FILT_KEEP, MW'(filt[m])};
      S_FLT_B:   mac_req = '{dmpi_pkg::MAC_ADD, dmpi_pkg::K_FILT_NEW, MW'(raw_r)};
      S_FLT_C:   mac_req = '{dmpi_pkg::MAC_ADD, dmpi_pkg::K_FILT_NEW, MW'(prev_raw[m])};
      S_INT_A:   mac_req = '{dmpi_pkg::MAC_LOAD, MW'(err), MW'($signed({1'b0, ms_eff}))};
      S_INT_B:   mac_req = '{dmpi_pkg::MAC_ADD, MW'(integ[m]), dmpi_pkg::K_MS_PER_S};
      S_INT_MUL: mac_req = '{dmpi_pkg::MAC_LOAD, MW'($signed({1'b0, int_mag})),
                             dmpi_pkg::K_RECIP_MS};
      S_OUT_A:   mac_req = '{dmpi_pkg::MAC_LOAD, MW'($signed({1'b0, prop_gain})), MW'(err)};
      S_OUT_B:   mac_req = '{dmpi_pkg::MAC_ADD, MW'($signed({1'b0, integ_gain})),
                             MW'(integ_n)};
      S_DTY_A:   mac_req = '{dmpi_pkg::MAC_LOAD, MW'($signed({1'b0, out_mag})),
                             dmpi_pkg::K_HUNDRED};
      S_DTY_B:   mac_req = '{dmpi_pkg::MAC_LOAD, MW'($signed({1'b0, acc[21:0]})),
                             dmpi_pkg::K_RECIP_DUTY};
      default:   mac_req = '{mode: dmpi_pkg::MAC_IDLE, a: '0, b: '0};
    endcase
  end

  dmpi_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .acc (acc)
  );

  dmpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (ms_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  assign update.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m           <= 1'b0;
      res_valid   <= 1'b0;
      prop_gain   <= dmpi_pkg::PROP_GAIN_RST;
      integ_gain  <= dmpi_pkg::INTEG_GAIN_RST;
      last_cnt[0] <= '0;
      last_cnt[1] <= '0;
      filt[0]     <= '0;
      filt[1]     <= '0;
      prev_raw[0] <= '0;
      prev_raw[1] <= '0;
      integ[0]    <= '0;
      integ[1]    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          dmpi_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data;
          dmpi_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data;
          default: ;
        endcase
      end

      // S_DONE refills the slot itself when it is taken
      if (result.valid && result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (update.valid) begin
            cnt[0] <= update.count_m1;
            cnt[1] <= update.count_m2;
            ms_eff <= (update.elapsed_ms == 16'd0) ? 16'd1 : update.elapsed_ms;
            target <= update.target_speed;
            m      <= 1'b0;
            if (update.action == dmpi_pkg::ACT_STOP) begin
              // Stop both motors; keep the previous raw speed
              filt[0]     <= '0;
              filt[1]     <= '0;
              integ[0]    <= '0;
              integ[1]    <= '0;
              last_cnt[0] <= update.count_m1;
              last_cnt[1] <= update.count_m2;
              duty_t[0]   <= '0;
              duty_t[1]   <= '0;
              rev_t[0]    <= 1'b0;
              rev_t[1]    <= 1'b0;
              state       <= S_DONE;
            end else begin
              state <= S_RAW_MUL;
            end
          end
        end
        S_RAW_MUL:  state <= S_RAW_WAIT;
        S_RAW_WAIT: state <= S_RAW_DIV;
        S_RAW_DIV: begin
          raw_neg <= acc[AW-1];
          state   <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            raw_r <= raw_neg ? (16'd0 - q16) : q16;
            state <= S_FLT_A;
          end
        end
        S_FLT_A:    state <= S_FLT_B;
        S_FLT_B:    state <= S_FLT_C;
        S_FLT_C:    state <= S_FLT_WAIT;
        S_FLT_WAIT: state <= S_FLT_SET;
        S_FLT_SET: begin
          filt_n <= sat16(acc_q16);
          state  <= S_INT_A;
        end
        S_INT_A:    state <= S_INT_B;
        S_INT_B:    state <= S_INT_WAIT;
        S_INT_WAIT: state <= S_INT_CLAMP;
        S_INT_CLAMP: begin
          int_neg <= acc[AW-1];
          int_sat <= (acc >= dmpi_pkg::INT_SUM_HI) || (acc <= dmpi_pkg::INT_SUM_LO);
          int_mag <= acc_abs[24:0];
          state   <= S_INT_MUL;
        end
        S_INT_MUL:   state <= S_INT_WAIT2;
        S_INT_WAIT2: state <= S_INT_SET;
        S_INT_SET: begin
          if (int_sat) begin
            integ_n <= int_neg ? 16'sh8000 : 16'sh7FFF;
          end else begin
            integ_n <= int_neg ? (16'd0 - int_q) : int_q;
          end
          state <= S_OUT_A;
        end
        S_OUT_A:    state <= S_OUT_B;
        S_OUT_B:    state <= S_OUT_WAIT;
        S_OUT_WAIT: state <= S_OUT_SET;
        S_OUT_SET: begin
          out_n <= sat16(acc_q8);
          state <= S_DTY_A;
        end
        S_DTY_A:     state <= S_DTY_WAIT;
        S_DTY_WAIT:  state <= S_DTY_B;
        S_DTY_B:     state <= S_DTY_WAIT2;
        S_DTY_WAIT2: state <= S_DTY_SET;
        S_DTY_SET: begin
          duty_t[m]   <= (dm > QW'(dmpi_pkg::DUTY_MAX)) ? dmpi_pkg::DUTY_MAX : dm[6:0];
          rev_t[m]    <= out_n[15] && (dm != '0);
          last_cnt[m] <= cnt[m];
          prev_raw[m] <= raw_r;
          filt[m]     <= filt_n;
          integ[m]    <= integ_n;
          if (m == 1'b0) begin
            m     <= 1'b1;
            state <= S_RAW_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the result slot is free
          if (!res_valid || result.ready) begin
            res_duty1 <= duty_t[0];
            res_rev1  <= rev_t[0];
            res_duty2 <= duty_t[1];
            res_rev2  <= rev_t[1];
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = res_valid;
  assign result.duty_m1    = res_duty1;
  assign result.reverse_m1 = res_rev1;
  assign result.duty_m2    = res_duty2;
  assign result.reverse_m2 = res_rev2;

endmodule

`default_nettype wire

/* src/dmpi_div.sv */
`default_nettype none

module dmpi_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [dmpi_pkg::DIV_NUM_W-1:0] dividend,
  input  wire logic [dmpi_pkg::DIV_DEN_W-1:0] divisor,
  output logic                                done,
  output logic [dmpi_pkg::DIV_NUM_W-1:0]      quotient
);

  localparam int NW    = dmpi_pkg::DIV_NUM_W;
  localparam int DW    = dmpi_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] step_cnt;
  logic             busy;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW-1:0] rem_next;

  // One quotient bit a cycle, most significant first
  always_comb begin
    trial    = {rem, quo[NW-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo      <= dividend;
        rem      <= '0;
        dsr      <= divisor;
        step_cnt <= CNT_W'(NW);
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= rem_next;
        quo      <= {quo[NW-2:0], fits};
        step_cnt <= step_cnt - CNT_W'(1);
        if (step_cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* src/dmpi_mac.sv */
`default_nettype none

module dmpi_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dmpi_pkg::mac_req_t               req,
  output logic signed [dmpi_pkg::ACC_W-1:0]     acc
);

  logic signed [dmpi_pkg::ACC_W-1:0] prod;
  dmpi_pkg::mac_mode_t               mode_d;

  // Product and mode are registered together; the accumulate into acc follows in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_d <= dmpi_pkg::MAC_IDLE;
    end else begin
      mode_d <= req.mode;
    end
    prod <= req.a * req.b;
    case (mode_d)
      dmpi_pkg::MAC_LOAD: acc <= prod;
      dmpi_pkg::MAC_ADD:  acc <= acc + prod;
      default:            acc <= acc;
    endcase
  end

endmodule

`default_nettype wire
